/* rtl/tssm_pkg.sv */
`default_nettype none

package tssm_pkg;

  // Table geometry and character width.
  localparam int NumPatterns = 8;
  localparam int MaxLen      = 8;
  localparam int CharBits    = 16;

  // Field widths of the stream beats.
  localparam int SlotW = 3;
  localparam int PosW  = 3;
  localparam int LenW  = 4;
  localparam int CurW  = 16;

  localparam int InDataW  = 64;
  localparam int InUserW  = 3;
  localparam int OutDataW = 48;
  localparam int OutUserW = 1;

  typedef logic [CharBits-1:0] char_t;
  typedef logic [SlotW-1:0]    slot_t;
  typedef logic [PosW-1:0]     pos_t;
  typedef logic [LenW-1:0]     len_t;
  typedef logic [CurW-1:0]     cur_t;

  // Window characters, index 0 is the most recent one.
  typedef char_t [MaxLen-1:0] win_chars_t;

  typedef enum logic [1:0] {
    REQ_KEY  = 2'd0,
    REQ_CHAR = 2'd1,
    REQ_LEN  = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_RESP
  } state_t;

  // Control of the window cells.
  typedef struct packed {
    logic shift;   // a character enters cell 0, the rest move up one cell
    logic flush;   // the characters held so far are dropped
  } win_ctl_t;

  // Control broadcast to the slot cells.
  typedef struct packed {
    logic  char_we;
    logic  len_we;
    slot_t slot;
    pos_t  pos;
    char_t code;
    len_t  len;
    logic  sweep;
    pos_t  cnt;
  } slot_ctl_t;

  // Best match handed along the slot chain.
  typedef struct packed {
    len_t  len;
    slot_t slot;
  } best_t;

endpackage

`default_nettype wire

/* rtl/typed_sequence_suffix_matcher_top.sv */
`default_nettype none

// Typed-sequence suffix matcher. The block holds eight pattern slots of up to
// eight 16-bit characters and a window of the most recently typed characters.
// Every input beat is one request, selected by in_tuser: a keystroke, a write
// of one pattern character, or a write of a slot length (length 0 empties the
// slot, lengths above eight saturate). A keystroke clears the window when the
// cursor did not move exactly one column right on the same line, appends its
// character if it carries one, and then looks for the longest stored pattern
// that equals the tail of the window, the lowest slot winning a tie. On a hit
// the result names the slot, the pattern length and the span of earlier
// characters to delete, and the window starts over. Every request returns
// exactly one result beat; writes and unknown requests return all zeros.
// A keystroke updates the window cells when it is taken; the compare in
// every slot cell and the best-match hand-off along the chain of slot cells
// then feed the output register. A pattern or length write is stored when
// taken, after which the written slot rebuilds its compare line one pattern
// character per cycle, up to its length, before the result is issued. The
// result sits in an output register, so a new request is taken while the
// previous result is still waiting for out_tready; a request only waits when
// its own result finds that register still full.
module typed_sequence_suffix_matcher_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input beats.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [2:0] slot, [5:3] char_pos, [21:6] char_code, [25:22] pattern_len,
  // [41:26] cursor_line, [57:42] cursor_col, [63:58] zero
  input  logic [tssm_pkg::InDataW-1:0]    in_tdata,
  // [1:0] req_type, [2] has_char
  input  logic [tssm_pkg::InUserW-1:0]    in_tuser,
  // Result beats.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [2:0] match_slot, [6:3] match_len, [22:7] delete_line,
  // [38:23] delete_col, [41:39] delete_count, [47:42] zero
  output logic [tssm_pkg::OutDataW-1:0]   out_tdata,
  // [0] matched
  output logic [tssm_pkg::OutUserW-1:0]   out_tuser
);
  import tssm_pkg::*;

  // Request fields.
  req_t  req;
  logic  has_char;
  slot_t f_slot;
  pos_t  f_pos;
  char_t f_code;
  len_t  f_plen;
  len_t  plen_sat;
  cur_t  f_line;
  cur_t  f_col;

  assign req      = req_t'(in_tuser[1:0]);
  assign has_char = in_tuser[2];
  assign f_slot   = in_tdata[2:0];
  assign f_pos    = in_tdata[5:3];
  assign f_code   = in_tdata[21:6];
  assign f_plen   = in_tdata[25:22];
  assign f_line   = in_tdata[41:26];
  assign f_col    = in_tdata[57:42];
  assign plen_sat = (f_plen > len_t'(MaxLen)) ? len_t'(MaxLen) : f_plen;

  // Control state.
  state_t state_r, state_nxt;
  pos_t   cnt_r, cnt_nxt;
  slot_t  sweep_slot_r, sweep_slot_nxt;
  logic   is_key_r, is_key_nxt;
  cur_t   last_line_r, last_line_nxt;
  cur_t   last_col_r, last_col_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic [OutDataW-1:0] out_data_r;
  logic [OutUserW-1:0] out_user_r;

  logic      in_acc;
  logic      out_free;
  logic      jump;
  logic      load;
  logic      found;
  win_ctl_t  win_ctl;
  slot_ctl_t slot_ctl;

  // Window cells and slot chain.
  win_chars_t        win_chars;
  logic [MaxLen-1:0] win_valid;
  logic [MaxLen-1:0] vld_inc;
  best_t             best_chain [NumPatterns+1];
  len_t              long_chain [NumPatterns+1];
  best_t             best;
  len_t              longest;

  logic [OutDataW-1:0] res_data;
  cur_t                del_col;
  pos_t                del_cnt;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // The column compare is one bit wider so that the last column never wraps.
  assign jump = (f_line != last_line_r) ||
                (({1'b0, last_col_r} + 17'd1) != {1'b0, f_col});

  assign best    = best_chain[NumPatterns];
  assign longest = long_chain[NumPatterns];
  assign found   = is_key_r && (best.len != '0);

  // Window: cell 0 holds the newest character, each shift hands every
  // character to the next cell up.
  for (genvar k = 0; k < MaxLen; k++) begin : g_win
    char_t c_in;
    logic  v_in;
    if (k == 0) begin : g_head
      assign c_in = f_code;
      assign v_in = 1'b1;
    end else begin : g_body
      assign c_in = win_chars[k-1];
      assign v_in = win_valid[k-1] & ~win_ctl.flush;
    end
    tssm_win_cell #(
      .IDX(k)
    ) u_win_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (win_ctl),
      .char_in  (c_in),
      .valid_in (v_in),
      .longest  (longest),
      .char_o   (win_chars[k]),
      .valid_o  (win_valid[k])
    );
  end

  // Slot cells: each compares its own pattern against the window and passes
  // the best match so far, and the running longest length, to its neighbor.
  assign best_chain[0] = '0;
  assign long_chain[0] = '0;

  for (genvar s = 0; s < NumPatterns; s++) begin : g_slot
    tssm_slot_cell #(
      .IDX(s)
    ) u_slot_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (slot_ctl),
      .win_chars   (win_chars),
      .win_valid   (win_valid),
      .best_in     (best_chain[s]),
      .longest_in  (long_chain[s]),
      .best_out    (best_chain[s+1]),
      .longest_out (long_chain[s+1])
    );
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (req)
            REQ_CHAR, REQ_LEN: state_nxt = ST_SWEEP;
            default:           state_nxt = ST_RESP;
          endcase
        end
      end
      ST_SWEEP: begin
        if (cnt_r == pos_t'(MaxLen - 1)) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    in_tready     = (state_r == ST_IDLE);
    win_ctl       = '0;
    slot_ctl      = '0;
    load          = 1'b0;
    slot_ctl.pos  = f_pos;
    slot_ctl.code = f_code;
    slot_ctl.len  = plen_sat;
    slot_ctl.slot = (state_r == ST_SWEEP) ? sweep_slot_r : f_slot;
    slot_ctl.cnt  = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          unique case (req)
            REQ_KEY: begin
              win_ctl.shift = has_char;
              win_ctl.flush = jump;
            end
            REQ_CHAR: slot_ctl.char_we = 1'b1;
            REQ_LEN:  slot_ctl.len_we  = 1'b1;
            default: ;
          endcase
        end
      end
      ST_SWEEP: slot_ctl.sweep = 1'b1;
      ST_RESP: begin
        if (out_free) begin
          load          = 1'b1;
          win_ctl.flush = found;
        end
      end
      default: ;
    endcase
  end

  // Sequencing registers and the cursor of the last keystroke.
  always_comb begin
    cnt_nxt        = (state_r == ST_SWEEP) ? (cnt_r + pos_t'(1)) : '0;
    sweep_slot_nxt = in_acc ? f_slot : sweep_slot_r;
    is_key_nxt     = in_acc ? (req == REQ_KEY) : is_key_r;
    last_line_nxt  = last_line_r;
    last_col_nxt   = last_col_r;
    if (in_acc && (req == REQ_KEY)) begin
      last_line_nxt = f_line;
      last_col_nxt  = f_col;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Result beat. The deletion span starts len-1 columns left of the cursor.
  always_comb begin
    del_col  = last_col_r - cur_t'(best.len) + cur_t'(1);
    del_cnt  = pos_t'(best.len - len_t'(1));
    res_data = '0;
    if (found) begin
      res_data = OutDataW'({del_cnt, del_col, last_line_r, best.len, best.slot});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      sweep_slot_r <= '0;
      is_key_r     <= 1'b0;
      last_line_r  <= '0;
      last_col_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      sweep_slot_r <= sweep_slot_nxt;
      is_key_r     <= is_key_nxt;
      last_line_r  <= last_line_nxt;
      last_col_r   <= last_col_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= res_data;
      out_user_r <= OutUserW'(found);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign vld_inc = win_valid + MaxLen'(1);

  // A match empties the window.
  a_match_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (load && found) |=> (win_valid == '0))
    else $error("window not empty after a match");

  // Occupied window cells always form one run starting at the newest cell.
  a_win_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((win_valid & vld_inc) == '0))
    else $error("window cells not contiguous");

  // The window never holds more characters than the longest pattern.
  a_win_trim: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(win_valid) <= int'($past(longest))))
    else $error("window longer than longest pattern");

  // A reported match carries a length and a delete count one below it.
  a_match_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_user_r[0]) |->
      ((out_data_r[6:3] != '0) &&
       (out_data_r[41:39] == pos_t'(out_data_r[6:3] - len_t'(1)))))
    else $error("inconsistent match result");

  // One request at a time: a taken beat holds off the next one.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("request taken while busy");

endmodule

`default_nettype wire

/* rtl/tssm_win_cell.sv */
`default_nettype none

module tssm_win_cell #(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tssm_pkg::win_ctl_t  ctl,
  input  tssm_pkg::char_t     char_in,
  input  logic                valid_in,
  input  tssm_pkg::len_t      longest,
  output tssm_pkg::char_t     char_o,
  output logic                valid_o
);
  import tssm_pkg::*;

  char_t char_r;
  logic  valid_r;
  logic  valid_nxt;

  // A cell only keeps a character while it lies within the longest pattern.
  always_comb begin
    valid_nxt = ctl.shift ? valid_in : (valid_r & ~ctl.flush);
    valid_nxt = valid_nxt & (len_t'(IDX) < longest);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      char_r <= char_in;
    end
  end

  assign char_o  = char_r;
  assign valid_o = valid_r;

endmodule

`default_nettype wire

/* rtl/tssm_slot_cell.sv */
`default_nettype none

module tssm_slot_cell #(
  parameter int IDX = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tssm_pkg::slot_ctl_t          ctl,
  input  tssm_pkg::win_chars_t         win_chars,
  input  logic [tssm_pkg::MaxLen-1:0]  win_valid,
  input  tssm_pkg::best_t              best_in,
  input  tssm_pkg::len_t               longest_in,
  output tssm_pkg::best_t              best_out,
  output tssm_pkg::len_t               longest_out
);
  import tssm_pkg::*;

  len_t  len_r;
  char_t raw_r  [MaxLen];
  char_t algn_r [MaxLen];
  logic  sel;
  logic  ok;
  logic  hit;

  assign sel = (ctl.slot == slot_t'(IDX));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (ctl.len_we && sel) begin
      len_r <= ctl.len;
    end
  end

  // Pattern characters in write order.
  always_ff @(posedge clk) begin
    if (ctl.char_we && sel) begin
      raw_r[ctl.pos] <= ctl.code;
    end
  end

  // Compare line: after the sweep has shifted in positions 0 to len-1,
  // entry k holds the pattern character that lines up with window cell k.
  always_ff @(posedge clk) begin
    if (ctl.sweep && sel && (len_t'(ctl.cnt) < len_r)) begin
      algn_r[0] <= raw_r[ctl.cnt];
      for (int k = 1; k < MaxLen; k++) begin
        algn_r[k] <= algn_r[k-1];
      end
    end
  end

  always_comb begin
    ok = 1'b1;
    for (int k = 0; k < MaxLen; k++) begin
      if (len_t'(k) < len_r) begin
        ok = ok & win_valid[k] & (win_chars[k] == algn_r[k]);
      end
    end
    hit = (len_r != '0) & ok;
  end

  // A strictly longer hit replaces the incoming one, so lower slots win ties.
  always_comb begin
    if (hit && (len_r > best_in.len)) begin
      best_out.len  = len_r;
      best_out.slot = slot_t'(IDX);
    end else begin
      best_out = best_in;
    end
    longest_out = (len_r > longest_in) ? len_r : longest_in;
  end

endmodule

`default_nettype wire

/* sim/tb_typed_sequence_suffix_matcher_top.sv */
`default_nettype none

module tb_typed_sequence_suffix_matcher_top;
  import tssm_pkg::*;

  // Request code 3 is not defined; the block must ignore it and answer zeros.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Cycles without any accepted beat on either side before the run is called hung.
  // The slowest legal gap is the long receiver hold-off below plus a pattern write.
  localparam int HANG_LIMIT   = 3000;
  localparam int RANDOM_ITEMS = 2000;
  localparam int LONG_HOLD    = 300;
  localparam int TAIL_CYCLES  = 30;

  // One request as the driver sees it, fields at the block's widths.
  typedef struct packed {
    logic [1:0] req;
    slot_t      slot;
    pos_t       pos;
    char_t      code;
    logic       has_char;
    len_t       plen;
    cur_t       line;
    cur_t       col;
  } request_t;

  // One result beat, unpacked into its fields.
  typedef struct packed {
    logic       matched;
    slot_t      slot;
    len_t       len;
    cur_t       del_line;
    cur_t       del_col;
    logic [2:0] del_count;
  } match_res_t;

  // A row of the directed table. When has_want is set the expected result is
  // the one typed in the row; otherwise the predictor supplies it.
  typedef struct packed {
    request_t   rq;
    logic       has_want;
    match_res_t want;
  } dir_row_t;

  localparam match_res_t NO_HIT    = '0;
  // "ab" typed at columns 10 and 11 of line 5, slot 0 wins the tie with slot 2.
  localparam match_res_t HIT_AB_10 = '{1'b1, 3'd0, 4'd2, 16'd5, 16'd10, 3'd1};
  // A lone "b" at column 12 of line 5 hits the one-character pattern in slot 1.
  localparam match_res_t HIT_B_12  = '{1'b1, 3'd1, 4'd1, 16'd5, 16'd12, 3'd0};

  logic clk = 1'b0;
  logic rst_n;

  logic                in_tvalid;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata;
  logic [InUserW-1:0]  in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;
  logic [OutUserW-1:0] out_tuser;

  typed_sequence_suffix_matcher_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: the pattern table, slot lengths, the typed window (oldest
  // character at the front) and the cursor position of the last keystroke.
  char_t pat_mem [NumPatterns][MaxLen];
  int    slot_len [NumPatterns];
  int    longest;
  char_t typed_q [$];
  cur_t  prev_line;
  cur_t  prev_col;

  // Positions written so far in each slot. Length writes never cover a
  // position that was not written, since its content is undefined.
  logic [MaxLen-1:0] pat_written [NumPatterns];

  // Results still to come from the block, oldest first.
  match_res_t pending_q [$];

  // Directed stimulus rows, walked in order.
  dir_row_t dir_tab [$];

  int  mismatches;
  int  items_done;
  int  keys_done;
  int  writes_done;
  int  hits_seen;
  bit  quiet;           // set in the closing stretch: no idling on either side
  bit  hold_req;        // asks the receiver for one long hold-off
  bit  hold_taken = 1'b0;
  int  hold_left;
  int  stall_left;
  int  hang_cnt = 0;

  // Drop the oldest window characters until at most keep remain.
  function automatic void trim_window(int keep);
    while (typed_q.size() > keep) void'(typed_q.pop_front());
  endfunction

  // Advance the predictor by one request and return the result it causes.
  function automatic match_res_t predict_match(request_t rq);
    match_res_t res;
    int         n;
    int         s;
    int         k;
    logic       hit;
    logic       same;
    res = '0;
    hit = 1'b0;
    case (rq.req)
      REQ_CHAR: pat_mem[rq.slot][rq.pos] = rq.code;
      REQ_LEN: begin
        slot_len[rq.slot] = (rq.plen > MaxLen) ? MaxLen : int'(rq.plen);
        longest = 0;
        for (s = 0; s < NumPatterns; s++)
          if (slot_len[s] > longest) longest = slot_len[s];
        trim_window(longest);
      end
      REQ_KEY: begin
        // The column sum is taken one bit wider, so column 65535 followed by
        // column 0 counts as a jump.
        if (rq.line != prev_line || ({1'b0, prev_col} + 17'd1) != {1'b0, rq.col})
          typed_q.delete();
        prev_line = rq.line;
        prev_col  = rq.col;
        if (rq.has_char) begin
          typed_q.insert(typed_q.size(), rq.code);
          if (typed_q.size() == longest + 1) trim_window(longest);
        end
        // Longest suffix first, lowest slot first within a length.
        for (n = typed_q.size(); n >= 1 && !hit; n--) begin
          for (s = 0; s < NumPatterns && !hit; s++) begin
            if (slot_len[s] == n) begin
              same = 1'b1;
              for (k = 0; k < n; k++)
                if (pat_mem[s][k] != typed_q[typed_q.size() - n + k]) same = 1'b0;
              if (same) begin
                hit           = 1'b1;
                res.matched   = 1'b1;
                res.slot      = slot_t'(s);
                res.len       = len_t'(n);
                res.del_line  = rq.line;
                res.del_col   = rq.col - cur_t'(n - 1);
                res.del_count = 3'(n - 1);
              end
            end
          end
        end
        if (hit) typed_q.delete();
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic request_t mk_req(logic [1:0] req, int slot, int pos, int code,
                                      int has_char, int plen, int line, int col);
    request_t rq;
    rq.req      = req;
    rq.slot     = slot_t'(slot);
    rq.pos      = pos_t'(pos);
    rq.code     = char_t'(code);
    rq.has_char = has_char[0];
    rq.plen     = len_t'(plen);
    rq.line     = cur_t'(line);
    rq.col      = cur_t'(col);
    return rq;
  endfunction

  // Append one row to the directed table.
  function automatic void add_row(request_t rq, logic has_want, match_res_t want);
    dir_row_t row;
    row.rq       = rq;
    row.has_want = has_want;
    row.want     = want;
    dir_tab.insert(dir_tab.size(), row);
  endfunction

  // Pattern and typed characters come mostly from a tiny alphabet, so that
  // suffixes overlap, shorter patterns fire inside longer ones and ties occur.
  function automatic char_t pick_char();
    int r;
    r = $urandom_range(0, 19);
    if (r < 16) return char_t'(16'h0061 + (r % 3));
    if (r == 16) return '0;
    if (r == 17) return '1;
    return char_t'($urandom);
  endfunction

  // Offer one beat, wait for it to be taken, record what the block must answer,
  // and sometimes leave the input idle for a burst of cycles.
  task automatic send_req(request_t rq, logic has_want = 1'b0, match_res_t want = '0);
    match_res_t res;
    in_tvalid <= 1'b1;
    in_tdata  <= {{(InDataW - 58){1'b0}}, rq.col, rq.line, rq.plen, rq.code,
                  rq.pos, rq.slot};
    in_tuser  <= {rq.has_char, rq.req};
    do @(posedge clk); while (in_tready !== 1'b1);
    res = predict_match(rq);
    if (has_want) res = want;
    pending_q.insert(pending_q.size(), res);
    if (res.matched) hits_seen++;
    if (rq.req == REQ_CHAR) pat_written[rq.slot][rq.pos] = 1'b1;
    if (rq.req != REQ_UNUSED) items_done++;
    if (rq.req == REQ_KEY) keys_done++;
    if (rq.req == REQ_CHAR || rq.req == REQ_LEN) writes_done++;
    // No gaps while the receiver holds off, so the block really fills up.
    if (!quiet && !(hold_req && !hold_taken) && hold_left == 0 &&
        $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic send_key(cur_t line, cur_t col, char_t code, logic has_char);
    send_req(mk_req(REQ_KEY, $urandom, $urandom, code, has_char, $urandom, line, col));
  endtask

  // A length write, preceded by writes of any position it covers that was
  // never written.
  task automatic send_len(int slot, int plen);
    int p;
    for (p = 0; p < plen && p < MaxLen; p++)
      if (!pat_written[slot][p])
        send_req(mk_req(REQ_CHAR, slot, p, pick_char(), $urandom, $urandom,
                        $urandom, $urandom));
    send_req(mk_req(REQ_LEN, slot, $urandom, $urandom, $urandom, plen,
                    $urandom, $urandom));
  endtask

  // Load a whole pattern: its characters, then its length. Up to a quarter of the
  // loads copy another, non-empty slot's pattern so that equal patterns compete.
  task automatic load_slot(int slot, int plen);
    int src;
    int n;
    int p;
    bit copy;
    src  = $urandom_range(0, NumPatterns - 1);
    copy = ($urandom_range(0, 3) == 0) && (slot_len[src] != 0) && (src != slot);
    n    = copy ? slot_len[src] : ((plen > MaxLen) ? MaxLen : plen);
    for (p = 0; p < n; p++)
      send_req(mk_req(REQ_CHAR, slot, p, copy ? int'(pat_mem[src][p]) : int'(pick_char()),
                      $urandom, $urandom, $urandom, $urandom));
    send_len(slot, copy ? n : plen);
  endtask

  // Type a few stray characters and then one stored pattern on consecutive
  // columns, now and then with a keystroke that carries no character or with
  // a cursor jump that breaks the run.
  task automatic type_run();
    cur_t line;
    cur_t col;
    int   cand [$];
    int   tgt;
    int   k;
    if ($urandom_range(0, 1)) begin
      line = prev_line;
      col  = prev_col + 1'b1;
    end else begin
      line = ($urandom_range(0, 3) == 0) ? cur_t'($urandom) : cur_t'($urandom_range(0, 15));
      col  = ($urandom_range(0, 4) == 0) ? cur_t'($urandom_range(65530, 65535))
                                         : cur_t'($urandom_range(0, 300));
    end
    for (k = 0; k < NumPatterns; k++)
      if (slot_len[k] != 0) cand.insert(cand.size(), k);
    repeat ($urandom_range(0, 3)) begin
      send_key(line, col, pick_char(), 1'b1);
      col++;
    end
    if (cand.size() == 0) return;
    tgt = cand[$urandom_range(0, cand.size() - 1)];
    for (k = 0; k < slot_len[tgt]; k++) begin
      if ($urandom_range(0, 11) == 0) begin
        send_key(line, col, char_t'($urandom), 1'b0);
        col++;
      end
      if ($urandom_range(0, 24) == 0) col += cur_t'($urandom_range(2, 5));
      send_key(line, col, pat_mem[tgt][k], 1'b1);
      col++;
    end
  endtask

  // Report one field that differs from its expectation.
  task automatic cmp_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Receiver: checks every accepted result beat against the oldest
  // expectation and drives out_tready, with random stall bursts and one long
  // hold-off on request.
  initial begin : receiver
    match_res_t got;
    match_res_t want;
    out_tready <= 1'b0;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
        got.matched   = out_tuser[0];
        got.slot      = out_tdata[2:0];
        got.len       = out_tdata[6:3];
        got.del_line  = out_tdata[22:7];
        got.del_col   = out_tdata[38:23];
        got.del_count = out_tdata[41:39];
        if (pending_q.size() == 0) begin
          $error("result beat with no request waiting for it");
          mismatches++;
        end else begin
          want = pending_q.pop_front();
          cmp_field("matched", want.matched, got.matched);
          cmp_field("match_slot", want.slot, got.slot);
          cmp_field("match_len", want.len, got.len);
          cmp_field("delete_line", want.del_line, got.del_line);
          cmp_field("delete_col", want.del_col, got.del_col);
          cmp_field("delete_count", want.del_count, got.del_count);
        end
      end
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: a run that stops moving beats on both sides is hung.
  always @(posedge clk) begin
    if ((in_tvalid === 1'b1 && in_tready === 1'b1) ||
        (out_tvalid === 1'b1 && out_tready === 1'b1)) begin
      hang_cnt <= 0;
    end else if (hang_cnt >= HANG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      hang_cnt <= hang_cnt + 1;
    end
  end

  initial begin : stimulus
    int       s;
    int       r;
    bit       held;
    bit       drained;
    mismatches  = 0;
    items_done  = 0;
    keys_done   = 0;
    writes_done = 0;
    hits_seen   = 0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    held        = 1'b0;
    drained     = 1'b0;
    longest     = 0;
    prev_line   = '0;
    prev_col    = '0;
    for (s = 0; s < NumPatterns; s++) begin
      slot_len[s]    = 0;
      pat_written[s] = '0;
      for (r = 0; r < MaxLen; r++) pat_mem[s][r] = '0;
    end

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Slot 0 and slot 2 both hold "ab" and slot 1 holds "b",
    // which exercises the tie rule, the longest-suffix rule, removal of a slot,
    // trimming of the window by a length write, and cursor jumps and wraps.
    add_row(mk_req(REQ_KEY, 0, 0, 16'h0078, 1, 0, 0, 0), 1'b1, NO_HIT);
    add_row(mk_req(REQ_UNUSED, 7, 7, 16'hFFFF, 1, 15, 16'hFFFF, 16'hFFFF), 1'b1, NO_HIT);
    add_row(mk_req(REQ_LEN, 3, 0, 0, 0, 0, 0, 0), 1'b1, NO_HIT);
    add_row(mk_req(REQ_CHAR, 0, 0, 16'h0061, 0, 0, 0, 0), 1'b1, NO_HIT);
    add_row(mk_req(REQ_CHAR, 0, 1, 16'h0062, 0, 0, 0, 0), 1'b1, NO_HIT);
    add_row(mk_req(REQ_CHAR, 2, 0, 16'h0061, 0, 0, 0, 0), 1'b1, NO_HIT);
    add_row(mk_req(REQ_CHAR, 2, 1, 16'h0062, 0, 0, 0, 0), 1'b1, NO_HIT);
    add_row(mk_req(REQ_CHAR, 1, 0, 16'h0062, 0, 0, 0, 0), 1'b1, NO_HIT);
    add_row(mk_req(REQ_LEN, 0, 0, 0, 0, 2, 0, 0), 1'b1, NO_HIT);
    add_row(mk_req(REQ_LEN, 2, 0, 0, 0, 2, 0, 0), 1'b1, NO_HIT);
    add_row(mk_req(REQ_LEN, 1, 0, 0, 0, 1, 0, 0), 1'b1, NO_HIT);
    add_row(mk_req(REQ_KEY, 0, 0, 16'h0061, 1, 0, 5, 10), 1'b0, NO_HIT);
    add_row(mk_req(REQ_KEY, 0, 0, 16'h0062, 1, 0, 5, 11), 1'b1, HIT_AB_10);
    add_row(mk_req(REQ_KEY, 0, 0, 16'h0062, 1, 0, 5, 12), 1'b1, HIT_B_12);
    // A keystroke that carries no character still runs the compare.
    add_row(mk_req(REQ_KEY, 0, 0, 16'h0061, 0, 0, 5, 13), 1'b0, NO_HIT);
    add_row(mk_req(REQ_KEY, 0, 0, 16'h0061, 1, 0, 5, 14), 1'b0, NO_HIT);
    // Removing slot 0 leaves slot 2 as the only "ab".
    add_row(mk_req(REQ_LEN, 0, 0, 0, 0, 0, 0, 0), 1'b1, NO_HIT);
    add_row(mk_req(REQ_KEY, 0, 0, 16'h0062, 1, 0, 5, 15), 1'b0, NO_HIT);
    add_row(mk_req(REQ_KEY, 0, 0, 16'h0062, 1, 0, 6, 16), 1'b0, NO_HIT);
    add_row(mk_req(REQ_KEY, 0, 0, 16'h0061, 1, 0, 6, 17), 1'b0, NO_HIT);
    // Longest length drops to one; the window keeps only its newest character.
    add_row(mk_req(REQ_LEN, 2, 0, 0, 0, 0, 0, 0), 1'b1, NO_HIT);
    add_row(mk_req(REQ_KEY, 0, 0, 16'h0062, 1, 0, 6, 18), 1'b0, NO_HIT);
    add_row(mk_req(REQ_CHAR, 7, 7, 16'hFFFF, 1, 15, 0, 0), 1'b1, NO_HIT);
    add_row(mk_req(REQ_KEY, 7, 7, 16'hFFFF, 1, 15, 16'hFFFF, 16'hFFFF), 1'b0, NO_HIT);
    // Column 65535 to column 0 is a jump, not a step.
    add_row(mk_req(REQ_KEY, 0, 0, 16'h0000, 1, 0, 16'hFFFF, 0), 1'b0, NO_HIT);
    add_row(mk_req(REQ_CHAR, 6, 0, 16'h0000, 0, 0, 0, 0), 1'b1, NO_HIT);
    foreach (dir_tab[i])
      send_req(dir_tab[i].rq, dir_tab[i].has_want, dir_tab[i].want);

    // Random part: mostly pattern loads followed by typing of stored
    // patterns, with length changes mid-run and some noise around them.
    r = items_done;
    while (items_done < r + RANDOM_ITEMS) begin
      if (!held && items_done >= r + 600) begin
        // The receiver holds off for a long stretch while requests keep coming.
        held     = 1'b1;
        hold_req = 1'b1;
      end
      if (!drained && items_done >= r + 1200) begin
        // The sender pauses until every outstanding result has come back.
        drained = 1'b1;
        in_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
      end
      if (items_done >= r + 1800) quiet = 1'b1;
      s = $urandom_range(0, 99);
      if (s < 12) begin
        s = $urandom_range(0, 9);
        load_slot($urandom_range(0, NumPatterns - 1),
                  (s == 0) ? 0 : ((s == 1) ? $urandom_range(MaxLen + 1, 15)
                                           : $urandom_range(1, MaxLen)));
      end else if (s < 22) begin
        send_len($urandom_range(0, NumPatterns - 1), $urandom_range(0, 15));
      end else if (s < 30) begin
        send_req(mk_req(REQ_CHAR, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom));
      end else if (s < 88) begin
        type_run();
      end else if (s < 96) begin
        send_req(mk_req(REQ_KEY, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom));
      end else begin
        send_req(mk_req(REQ_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom));
      end
    end

    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d requests: %0d keystrokes and %0d pattern or length writes.",
             items_done, keys_done, writes_done);
    $display("Keystrokes completed a stored pattern %0d times.", hits_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
rtl/tssm_pkg.sv
rtl/tssm_win_cell.sv
rtl/tssm_slot_cell.sv
rtl/typed_sequence_suffix_matcher_top.sv
sim/tb_typed_sequence_suffix_matcher_top.sv
